@@ rtl/pwl_pkg.sv @@
// Shared types and constants for the piecewise-linear evaluator.
// Used by the divider, the sequencer and the top level; no dependencies.
`default_nettype none
package pwl_pkg;
    localparam int DataWidth = 32;
    localparam int ResWidth  = 64;
    localparam int MagWidth  = 64;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_EVAL  = 2'd1,
        OP_DELTA = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    // Signed-magnitude value as used by the arithmetic path.
    typedef struct packed {
        logic                neg;
        logic [MagWidth-1:0] mag;
    } smag_t;

    // Handshake between the sequencer and the shared divider.
    typedef struct packed {
        logic                start;
        logic [MagWidth-1:0] dividend;
        logic [32:0]         divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [MagWidth-1:0] quotient;
    } div_rsp_t;

    // Saturate a signed-magnitude value to the signed 64-bit range.
    function automatic logic [ResWidth-1:0] sm_sat(input smag_t a);
        logic [ResWidth-1:0] r;
        if (!a.neg) begin
            r = a.mag[MagWidth-1] ? {1'b0, {(ResWidth-1){1'b1}}} : a.mag;
        end else if (a.mag[MagWidth-1]) begin
            r = {1'b1, {(ResWidth-1){1'b0}}};
        end else begin
            r = ~a.mag + 64'd1;
        end
        return r;
    endfunction

    // Signed-magnitude addition.
    function automatic smag_t sm_add(input smag_t a, input smag_t b);
        smag_t r;
        if (a.neg == b.neg) begin
            r.neg = a.neg;
            r.mag = a.mag + b.mag;
        end else if (a.mag >= b.mag) begin
            r.neg = a.neg;
            r.mag = a.mag - b.mag;
        end else begin
            r.neg = b.neg;
            r.mag = b.mag - a.mag;
        end
        return r;
    endfunction

    // Signed 64-bit value to signed-magnitude form.
    function automatic smag_t sm_of(input logic [ResWidth-1:0] v);
        smag_t r;
        r.neg = v[ResWidth-1];
        r.mag = r.neg ? (~v + 64'd1) : v;
        return r;
    endfunction
endpackage
`default_nettype wire

@@ rtl/pwl_divider.sv @@
// Radix-2 restoring divider: 64-bit unsigned dividend by 33-bit divisor.
// Depends on pwl_pkg; one quotient bit per cycle.
`default_nettype none
module pwl_divider
    import pwl_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);
    logic [MagWidth-1:0] quo_reg, quo_next;
    logic [33:0]         rem_reg, rem_next;
    logic [32:0]         dvs_reg, dvs_next;
    logic [6:0]          cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [34:0]         trial;
    logic [33:0]         shifted;

    // One shift-and-subtract step per cycle.
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[32:0], quo_reg[MagWidth-1]};
        trial     = {1'b0, shifted} - {2'b00, dvs_reg};
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[34]) begin
                rem_next = trial[33:0];
                quo_next = {quo_reg[MagWidth-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[MagWidth-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule
`default_nettype wire

@@ rtl/piecewise_linear_evaluator.sv @@
// Piecewise-linear evaluator. One item is taken at a time, and s_ready stays low
// from an input transfer until its result has been transferred. A load writes
// the table entry and then returns its result; a delta between equal points or
// an unused opcode goes straight to the output state. An evaluate runs one pass,
// and a delta between distinct points always runs two passes.
// Each pass is made of these steps. The first and the last active breakpoint are
// read. A binary search follows with one registered table read per probe, unless
// the query lies outside the table. Both end points of the segment are read. The
// differences are formed, then one 32x32 multiply, then the shared bit-serial
// divider is started and run to completion, and a final combine follows.
// Breakpoint entries that were never loaded read as undefined.
// Depends on pwl_pkg and pwl_divider.
`default_nettype none
module piecewise_linear_evaluator
    import pwl_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [6:0]           cfg_points_in_use,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_opcode,
    input  wire logic [5:0]           s_entry_index,
    input  wire logic signed [31:0]   s_point_a,
    input  wire logic signed [31:0]   s_point_b,
    input  wire logic signed [31:0]   s_entry_y,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic signed [63:0]        m_result_value
);
    localparam int AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = AW + 1;

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_LOAD   = 15'b000000000000010,
        S_RDF    = 15'b000000000000100,
        S_RDL    = 15'b000000000001000,
        S_CLMP   = 15'b000000000010000,
        S_PROBE  = 15'b000000000100000,
        S_CMP    = 15'b000000001000000,
        S_RD0    = 15'b000000010000000,
        S_RD1    = 15'b000000100000000,
        S_MUL    = 15'b000001000000000,
        S_PROD   = 15'b000010000000000,
        S_DSTART = 15'b000100000000000,
        S_DIV    = 15'b001000000000000,
        S_COMB   = 15'b010000000000000,
        S_OUT    = 15'b100000000000000
    } state_t;

    // Breakpoint table, one read port, registered read data.
    logic [31:0]   knot_x [MAX_POINTS];
    logic [31:0]   knot_y [MAX_POINTS];
    logic [AW-1:0] rd_addr;
    logic [31:0]   rdx_reg, rdy_reg;

    state_t        state_reg, state_next;
    logic [6:0]    piu_reg;
    logic          mval_reg;
    logic [1:0]    op_reg;
    logic [5:0]    idx_reg;
    logic [31:0]   pa_reg, pb_reg, py_reg;
    logic          pass_reg;          // 0 first point, 1 second point
    logic [31:0]   qx_reg;            // query point of this pass
    logic [31:0]   xf_reg;            // first breakpoint x
    logic [AW-1:0] lo_reg, hi_reg, mid_reg, seg_reg, sega_reg;
    logic [31:0]   x0_reg, y0_reg;
    logic          dxz_reg, dxn_reg, dyn_reg, nn_reg, qneg_reg;
    logic [31:0]   dxm_reg, dym_reg, nm_reg;
    logic [63:0]   prod_reg;
    logic [63:0]   evala_reg;
    logic [63:0]   res_reg;

    logic [CW-1:0] cnt_lim;
    logic [AW-1:0] last_idx;
    logic [AW-1:0] mid_calc;
    logic          use_slope;
    logic signed [32:0] dx_w, dy_w, num_w;
    smag_t         quo_sm, tot_sm, neg_a;
    div_req_t      dreq;
    div_rsp_t      drsp;

    pwl_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    // Effective breakpoint count clamped to the table, and the search midpoint.
    always_comb begin
        if (piu_reg < 7'd2) begin
            cnt_lim = CW'(2);
        end else if ({25'd0, piu_reg} > 32'(MAX_POINTS)) begin
            cnt_lim = CW'(MAX_POINTS);
        end else begin
            cnt_lim = CW'(piu_reg);
        end
        last_idx = AW'(cnt_lim - CW'(1));
        mid_calc = AW'(({1'b0, lo_reg} + {1'b0, hi_reg} + CW'(1)) >> 1);
    end

    assign s_ready        = (state_reg == S_IDLE) && !mval_reg;
    assign cfg_ready      = 1'b1;
    assign m_valid        = mval_reg;
    assign m_result_value = res_reg;

    // Table address select.
    always_comb begin
        unique case (state_reg)
            S_RDF:   rd_addr = '0;
            S_RDL:   rd_addr = last_idx;
            S_PROBE: rd_addr = mid_calc;
            S_RD0:   rd_addr = seg_reg;
            S_RD1:   rd_addr = seg_reg + AW'(1);
            default: rd_addr = '0;
        endcase
    end

    // Table write on a load, registered read every cycle.
    always_ff @(posedge aclk) begin
        if (state_reg == S_LOAD && {26'd0, idx_reg} < 32'(MAX_POINTS)) begin
            knot_x[AW'(idx_reg)] <= pa_reg;
            knot_y[AW'(idx_reg)] <= py_reg;
        end
        rdx_reg <= knot_x[rd_addr];
        rdy_reg <= knot_y[rd_addr];
    end

    // Divider request: offset times rise over run, magnitudes only.
    always_comb begin
        dreq.start    = (state_reg == S_DSTART);
        dreq.dividend = prod_reg;
        dreq.divisor  = {1'b0, dxm_reg};
    end

    // Segment differences and the combine step.
    always_comb begin
        use_slope  = pass_reg && (seg_reg == sega_reg);
        dx_w       = 33'($signed(rdx_reg)) - 33'($signed(x0_reg));
        dy_w       = 33'($signed(rdy_reg)) - 33'($signed(y0_reg));
        num_w      = use_slope ? 33'($signed(pb_reg)) - 33'($signed(pa_reg))
                               : 33'($signed(qx_reg)) - 33'($signed(x0_reg));
        quo_sm.neg = dxz_reg ? 1'b0 : qneg_reg;
        quo_sm.mag = dxz_reg ? '0 : drsp.quotient;
        tot_sm     = sm_add(sm_of(64'($signed(y0_reg))), quo_sm);
        neg_a      = sm_of(evala_reg);
        neg_a.neg  = ~neg_a.neg;
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    if (s_opcode == OP_LOAD) begin
                        state_next = S_LOAD;
                    end else if (s_opcode == OP_EVAL) begin
                        state_next = S_RDF;
                    end else if (s_opcode == OP_DELTA && s_point_a != s_point_b) begin
                        state_next = S_RDF;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_LOAD:  state_next = S_OUT;
            S_RDF:   state_next = S_RDL;
            S_RDL:   state_next = S_CLMP;
            S_CLMP: begin
                if ($signed(qx_reg) <= $signed(xf_reg)
                    || $signed(qx_reg) >= $signed(rdx_reg)) begin
                    state_next = S_RD0;
                end else begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE: state_next = (lo_reg >= hi_reg) ? S_RD0 : S_CMP;
            S_CMP:   state_next = S_PROBE;
            S_RD0:   state_next = S_RD1;
            S_RD1:   state_next = S_MUL;
            S_MUL:   state_next = S_PROD;
            S_PROD:  state_next = S_DSTART;
            S_DSTART: state_next = S_DIV;
            S_DIV:   state_next = drsp.done ? S_COMB : S_DIV;
            S_COMB: begin
                if (op_reg == OP_DELTA && !pass_reg) begin
                    state_next = S_RDF;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            piu_reg   <= 7'd2;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                piu_reg <= cfg_points_in_use;
            end
            if (state_reg == S_OUT) begin
                mval_reg <= 1'b1;
            end else if (mval_reg && m_ready) begin
                mval_reg <= 1'b0;
            end
        end
    end

    // Datapath registers, loaded by sequencer state.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    op_reg   <= s_opcode;
                    idx_reg  <= s_entry_index;
                    pa_reg   <= s_point_a;
                    pb_reg   <= s_point_b;
                    py_reg   <= s_entry_y;
                    qx_reg   <= s_point_a;
                    pass_reg <= 1'b0;
                    res_reg  <= '0;
                end
            end
            S_RDL: begin
                xf_reg <= rdx_reg;
            end
            S_CLMP: begin
                // rdx_reg holds the last active x; clamp outside the table.
                lo_reg <= '0;
                hi_reg <= AW'(cnt_lim - CW'(2));
                if ($signed(qx_reg) <= $signed(xf_reg)) begin
                    seg_reg <= '0;
                end else if ($signed(qx_reg) >= $signed(rdx_reg)) begin
                    seg_reg <= AW'(cnt_lim - CW'(2));
                end
            end
            S_PROBE: begin
                if (lo_reg >= hi_reg) begin
                    seg_reg <= lo_reg;
                end
                mid_reg <= mid_calc;
            end
            S_CMP: begin
                // rdx_reg holds x at the probed middle.
                if ($signed(rdx_reg) <= $signed(qx_reg)) begin
                    lo_reg <= mid_reg;
                end else begin
                    hi_reg <= mid_reg - AW'(1);
                end
            end
            S_RD1: begin
                x0_reg <= rdx_reg;
                y0_reg <= rdy_reg;
            end
            S_MUL: begin
                // Segment end point is in the read registers now.
                dxz_reg <= (dx_w == '0);
                dxn_reg <= dx_w[32];
                dxm_reg <= dx_w[32] ? 32'(-dx_w) : 32'(dx_w);
                dyn_reg <= dy_w[32];
                dym_reg <= dy_w[32] ? 32'(-dy_w) : 32'(dy_w);
                nn_reg  <= num_w[32];
                nm_reg  <= num_w[32] ? 32'(-num_w) : 32'(num_w);
            end
            S_PROD: begin
                prod_reg <= 64'(nm_reg) * 64'(dym_reg);
                qneg_reg <= (nn_reg != dyn_reg) != dxn_reg;
            end
            S_COMB: begin
                if (op_reg == OP_EVAL) begin
                    res_reg <= sm_sat(tot_sm);
                end else if (!pass_reg) begin
                    // First point done; locate the second one next.
                    evala_reg <= sm_sat(tot_sm);
                    pass_reg  <= 1'b1;
                    qx_reg    <= pb_reg;
                    sega_reg  <= seg_reg;
                end else if (use_slope) begin
                    res_reg <= sm_sat(quo_sm);
                end else begin
                    res_reg <= sm_sat(sm_add(sm_of(sm_sat(tot_sm)), neg_a));
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/pwl_checker.sv @@
// Port-level checker for the piecewise-linear evaluator and its bind.
// Depends on the top level's ports only.
`default_nettype none
module pwl_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [63:0] m_result_value
);
    // A held result keeps its value until the transfer.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_result_value))
        else $error("result changed while stalled");
    // A pending result stays pending.
    a_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped");
    // No input is taken while a result waits.
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken with result pending");
    // After an input transfer the block is busy.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after transfer");
endmodule

bind piecewise_linear_evaluator pwl_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_result_value(m_result_value)
);
`default_nettype wire
